// ===== rtl/core/gcl_pkg.sv =====
// ----------------------------------------------------------------------------
// gcl_pkg
// shared constants, types and helpers of the grid cell locator
// ----------------------------------------------------------------------------
package gcl_pkg;

    // edge table geometry
    localparam int MAX_CELLS  = 1024;
    localparam int IDX_W      = $clog2(MAX_CELLS);
    localparam int NUM_DIMS   = 3;

    // field widths
    localparam int COORD_W    = 32;
    localparam int CELL_W     = 10;
    localparam int SLOT_W     = 10;
    localparam int EDGE_DIM_W = 2;
    localparam int DIMS_W     = 2;
    localparam int TOP_W      = 10;
    localparam int TOTAL_W    = 11;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 11;

    localparam logic [CFG_IDX_W-1:0] CFG_DIMS_USED     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SEARCH_TOP_X  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SEARCH_TOP_Y  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SEARCH_TOP_Z  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_CELLS_X = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_CELLS_Y = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_CELLS_Z = 3'd6;

    // configuration reset values
    localparam logic [DIMS_W-1:0]  RST_DIMS_USED   = 2'd3;
    localparam logic [TOP_W-1:0]   RST_SEARCH_TOP  = 10'd1023;
    localparam logic [TOTAL_W-1:0] RST_TOTAL_CELLS = 11'd1024;

    // command codes
    localparam logic CMD_LOAD   = 1'b0;
    localparam logic CMD_LOCATE = 1'b1;

    // command queue between front and back
    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef struct packed {
        logic [DIMS_W-1:0]                  dims_used;
        logic [NUM_DIMS-1:0][TOP_W-1:0]     search_top;
        logic [NUM_DIMS-1:0][TOTAL_W-1:0]   total_cells;
    } t_cfg;

    typedef struct packed {
        logic                               locate;
        logic [NUM_DIMS-1:0]                wr_lane;
        logic [IDX_W-1:0]                   slot;
        logic [COORD_W-1:0]                 coord;
        logic [NUM_DIMS-1:0][COORD_W-1:0]   pos;
    } t_item;

    typedef struct packed {
        logic [NUM_DIMS-1:0][CELL_W-1:0]    cell_idx;
        logic                               outside;
    } t_result;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_DONE
    } t_back_state;

    // clamp a search top to the last table entry
    function automatic logic [IDX_W-1:0] sat_top(input logic [TOP_W-1:0] top);
        logic [IDX_W-1:0] res;
        if (32'(top) > MAX_CELLS - 1) begin
            res = IDX_W'(MAX_CELLS - 1);
        end else begin
            res = IDX_W'(top);
        end
        return res;
    endfunction

endpackage

// ===== rtl/core/gcl_front.sv =====
// ----------------------------------------------------------------------------
// gcl_front
// input side: decodes each transaction and queues work for the back end
// ----------------------------------------------------------------------------
module gcl_front
    import gcl_pkg::*;
(
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_push,
    output logic                          o_full,
    input  logic                          i_cmd,
    input  logic [EDGE_DIM_W-1:0]         i_edge_dim,
    input  logic [SLOT_W-1:0]             i_edge_slot,
    input  logic signed [COORD_W-1:0]     i_edge_coord,
    input  logic signed [COORD_W-1:0]     i_pos_x,
    input  logic signed [COORD_W-1:0]     i_pos_y,
    input  logic signed [COORD_W-1:0]     i_pos_z,
    output logic                          o_q_valid,
    output t_item                         o_q_item,
    input  logic                          i_q_pop
);

    t_item               r_q [QDEPTH];
    logic [QPTR_W-1:0]   r_wr_ptr, n_wr_ptr;
    logic [QPTR_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic [QCNT_W-1:0]   r_count, n_count;
    t_item               item;
    logic                slot_ok;
    logic                accept;
    logic                enq;
    logic                deq;

    // classify: loads to a bad dimension or slot are dropped here
    always_comb begin
        slot_ok       = 32'(i_edge_slot) < MAX_CELLS;
        item.locate   = (i_cmd == CMD_LOCATE);
        for (int d = 0; d < NUM_DIMS; d++) begin
            item.wr_lane[d] = (i_cmd == CMD_LOAD) && slot_ok
                              && (32'(i_edge_dim) == d);
        end
        item.slot     = IDX_W'(i_edge_slot);
        item.coord    = i_edge_coord;
        item.pos[0]   = i_pos_x;
        item.pos[1]   = i_pos_y;
        item.pos[2]   = i_pos_z;
    end

    assign o_full    = (r_count == QCNT_W'(QDEPTH));
    assign accept    = i_push && !o_full;
    assign enq       = accept && (item.locate || (|item.wr_lane));
    assign o_q_valid = (r_count != '0);
    assign deq       = i_q_pop && o_q_valid;
    assign o_q_item  = r_q[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (enq) begin
            n_wr_ptr = (r_wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (deq) begin
            n_rd_ptr = (r_rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (enq && !deq) begin
            n_count = r_count + 1'b1;
        end else if (deq && !enq) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (enq) begin
            r_q[r_wr_ptr] <= item;
        end
    end

endmodule

// ===== rtl/core/gcl_lane.sv =====
// ----------------------------------------------------------------------------
// gcl_lane
// one dimension: edge table memory and a one-step-per-cycle binary search
// ----------------------------------------------------------------------------
module gcl_lane
    import gcl_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_wr_en,
    input  logic [IDX_W-1:0]       i_wr_addr,
    input  logic [COORD_W-1:0]     i_wr_data,
    input  logic                   i_start,
    input  logic [COORD_W-1:0]     i_pos,
    input  logic [IDX_W-1:0]       i_top,
    output logic                   o_busy,
    output logic [IDX_W-1:0]       o_cell
);

    logic [COORD_W-1:0]  r_mem [MAX_CELLS];
    logic [COORD_W-1:0]  r_rdata;
    logic [IDX_W-1:0]    r_lo, n_lo;
    logic [IDX_W-1:0]    r_hi, n_hi;
    logic [IDX_W-1:0]    r_mid;
    logic [COORD_W-1:0]  r_pos, n_pos;
    logic                r_active, n_active;
    logic [IDX_W-1:0]    rd_addr;
    logic                pos_less;

    // signed compare against the edge read for the current midpoint
    assign pos_less = $signed(r_pos) < $signed(r_rdata);

    always_comb begin
        n_lo     = r_lo;
        n_hi     = r_hi;
        n_pos    = r_pos;
        n_active = r_active;
        if (i_start) begin
            n_lo     = '0;
            n_hi     = i_top;
            n_pos    = i_pos;
            n_active = (i_top != '0);
        end else if (r_active) begin
            if (pos_less) begin
                n_hi = r_mid;
            end else begin
                n_lo = r_mid + 1'b1;
            end
            n_active = (n_lo != n_hi);
        end
        // next midpoint is fetched at the same edge the bounds move
        rd_addr = n_lo + ((n_hi - n_lo) >> 1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
        end else begin
            r_active <= n_active;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lo  <= n_lo;
        r_hi  <= n_hi;
        r_pos <= n_pos;
        r_mid <= rd_addr;
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rdata <= r_mem[rd_addr];
    end

    assign o_busy = r_active;
    assign o_cell = r_hi;

endmodule

// ===== rtl/core/gcl_back.sv =====
// ----------------------------------------------------------------------------
// gcl_back
// work side: writes edges, runs the three search lanes, holds the result
// ----------------------------------------------------------------------------
module gcl_back
    import gcl_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cfg       i_cfg,
    input  logic       i_q_valid,
    input  t_item      i_q_item,
    output logic       o_q_pop,
    output logic       o_empty,
    input  logic       i_pop,
    output t_result    o_result
);

    t_back_state               r_state, n_state;
    logic                      r_out_valid, n_out_valid;
    t_result                   r_out;
    logic                      load_out;
    t_result                   res;
    logic [NUM_DIMS-1:0]       used;
    logic [NUM_DIMS-1:0]       lane_wr;
    logic [NUM_DIMS-1:0]       lane_start;
    logic [NUM_DIMS-1:0]       lane_busy;
    logic [IDX_W-1:0]          lane_cell [NUM_DIMS];

    always_comb begin
        for (int d = 0; d < NUM_DIMS; d++) begin
            used[d] = 32'(i_cfg.dims_used) > d;
        end
    end

    for (genvar d = 0; d < NUM_DIMS; d++) begin : g_lane
        gcl_lane u_lane (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_wr_en   (lane_wr[d]),
            .i_wr_addr (i_q_item.slot),
            .i_wr_data (i_q_item.coord),
            .i_start   (lane_start[d]),
            .i_pos     (i_q_item.pos[d]),
            .i_top     (sat_top(i_cfg.search_top[d])),
            .o_busy    (lane_busy[d]),
            .o_cell    (lane_cell[d])
        );
    end

    // dimensions in order; the first one out of range sets outside, later ones stay zero
    always_comb begin
        logic live;
        logic fail;
        live = 1'b1;
        fail = 1'b0;
        res  = '0;
        for (int d = 0; d < NUM_DIMS; d++) begin
            if (live && used[d]) begin
                res.cell_idx[d] = CELL_W'(lane_cell[d]);
                fail            = 32'(lane_cell[d]) >= 32'(i_cfg.total_cells[d]);
                if (fail) begin
                    res.outside = 1'b1;
                    live        = 1'b0;
                end
            end
        end
    end

    always_comb begin
        n_state     = r_state;
        o_q_pop     = 1'b0;
        lane_wr     = '0;
        lane_start  = '0;
        load_out    = 1'b0;
        n_out_valid = r_out_valid && !i_pop;
        unique case (r_state)
            ST_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    if (i_q_item.locate) begin
                        lane_start = used;
                        n_state    = ST_SEARCH;
                    end else begin
                        lane_wr    = i_q_item.wr_lane;
                    end
                end
            end
            ST_SEARCH: begin
                if (lane_busy == '0) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!r_out_valid || i_pop) begin
                    load_out    = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out <= res;
        end
    end

    assign o_empty  = !r_out_valid;
    assign o_result = r_out;

endmodule

// ===== rtl/core/grid_cell_locator.sv =====
// ----------------------------------------------------------------------------
// grid_cell_locator
// locates the grid cell of a particle by binary search over per-axis edges
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake                 payload
//  input     in         push / full               cmd, edge_dim, edge_slot,
//                                                 edge_coord, pos_x/y/z
//  result    out        empty / pop               cell_x/y/z, outside
//  config    in         cfg_valid / cfg_ready     cfg_index, cfg_data
//
//  a load transaction is written by the back end without leaving idle; a
//  locate runs a binary search in every used lane, each reading its edge
//  memory once per halving step; the three axes run in parallel lanes, so
//  the slowest axis sets when the locate is done
//  reset is synchronous; it empties both queues and restores the register
//  defaults, edge memories keep their contents
//  a two-entry queue lets input transactions arrive while a search runs, and
//  a held result stalls only the back end
//
module grid_cell_locator
    import gcl_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // input queue side
    input  logic                       push,
    output logic                       full,
    input  logic                       i_cmd,
    input  logic [EDGE_DIM_W-1:0]      i_edge_dim,
    input  logic [SLOT_W-1:0]          i_edge_slot,
    input  logic signed [COORD_W-1:0]  i_edge_coord,
    input  logic signed [COORD_W-1:0]  i_pos_x,
    input  logic signed [COORD_W-1:0]  i_pos_y,
    input  logic signed [COORD_W-1:0]  i_pos_z,
    // result queue side
    output logic                       empty,
    input  logic                       pop,
    output logic [CELL_W-1:0]          o_cell_x,
    output logic [CELL_W-1:0]          o_cell_y,
    output logic [CELL_W-1:0]          o_cell_z,
    output logic                       o_outside,
    // register writes
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [CFG_DATA_W-1:0]      i_cfg_data
);

    t_cfg     r_cfg;
    logic     q_valid;
    t_item    q_item;
    logic     q_pop;
    t_result  result;

    // registers are always writable; writes belong in idle periods only
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.dims_used   <= RST_DIMS_USED;
            r_cfg.search_top  <= {NUM_DIMS{RST_SEARCH_TOP}};
            r_cfg.total_cells <= {NUM_DIMS{RST_TOTAL_CELLS}};
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_DIMS_USED:     r_cfg.dims_used      <= i_cfg_data[DIMS_W-1:0];
                CFG_SEARCH_TOP_X:  r_cfg.search_top[0]  <= i_cfg_data[TOP_W-1:0];
                CFG_SEARCH_TOP_Y:  r_cfg.search_top[1]  <= i_cfg_data[TOP_W-1:0];
                CFG_SEARCH_TOP_Z:  r_cfg.search_top[2]  <= i_cfg_data[TOP_W-1:0];
                CFG_TOTAL_CELLS_X: r_cfg.total_cells[0] <= i_cfg_data[TOTAL_W-1:0];
                CFG_TOTAL_CELLS_Y: r_cfg.total_cells[1] <= i_cfg_data[TOTAL_W-1:0];
                CFG_TOTAL_CELLS_Z: r_cfg.total_cells[2] <= i_cfg_data[TOTAL_W-1:0];
                default: begin
                    // unmapped index, write is dropped
                end
            endcase
        end
    end

    // front end: takes each transaction while not full, drops loads that address nothing
    gcl_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .o_full       (full),
        .i_cmd        (i_cmd),
        .i_edge_dim   (i_edge_dim),
        .i_edge_slot  (i_edge_slot),
        .i_edge_coord (i_edge_coord),
        .i_pos_x      (i_pos_x),
        .i_pos_y      (i_pos_y),
        .i_pos_z      (i_pos_z),
        .o_q_valid    (q_valid),
        .o_q_item     (q_item),
        .i_q_pop      (q_pop)
    );

    // back end: edge writes, searches, and the result register
    gcl_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_q_valid (q_valid),
        .i_q_item  (q_item),
        .o_q_pop   (q_pop),
        .o_empty   (empty),
        .i_pop     (pop),
        .o_result  (result)
    );

    assign o_cell_x  = result.cell_idx[0];
    assign o_cell_y  = result.cell_idx[1];
    assign o_cell_z  = result.cell_idx[2];
    assign o_outside = result.outside;

endmodule

// ===== rtl/core/gcl_checker.sv =====
// ----------------------------------------------------------------------------
// gcl_checker
// port-level checks of the grid cell locator, bound to the top level
// ----------------------------------------------------------------------------
module gcl_checker
    import gcl_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    input  logic               full,
    input  logic               empty,
    input  logic               pop,
    input  logic [CELL_W-1:0]  o_cell_x,
    input  logic [CELL_W-1:0]  o_cell_y,
    input  logic [CELL_W-1:0]  o_cell_z,
    input  logic               o_outside
);

    // a waiting result stays put until taken
    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !pop |=> !empty && $stable(o_cell_x) && $stable(o_cell_y)
                           && $stable(o_cell_z) && $stable(o_outside))
        else $error("result changed while waiting");

    // reset leaves the result queue empty and the input queue not full
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> empty && !full)
        else $error("queues not empty after reset");

    // input queue fills only by a push
    a_full_needs_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !full && !push |=> !full)
        else $error("input queue filled without a push");

    // queue flags always carry a known value out of reset
    a_flags_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$isunknown({full, empty}))
        else $error("queue flag unknown");

endmodule

bind grid_cell_locator gcl_checker u_gcl_checker (.*);
